// File: src/uac_pkg.sv
// Shared types and constants for the utilization admission control block.
`default_nettype none
package uac_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int LIM_W  = 7;
  localparam int ST_W   = 3;
  localparam int CMP_W  = 71;

  localparam logic [WORD_W-1:0] STEP_NS    = 64'd1000;
  localparam logic [WORD_W-1:0] PCT_SCALE  = 64'd100;
  localparam logic [LIM_W-1:0]  LIMIT_RST  = 7'd90;

  // result status codes
  localparam logic [ST_W-1:0] ST_FIT     = 3'd0;
  localparam logic [ST_W-1:0] ST_REALIGN = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [ST_W-1:0] ST_BADRES  = 3'd3;
  localparam logic [ST_W-1:0] ST_LIMIT   = 3'd4;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd5;

  localparam logic OP_ADD = 1'b1;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_res_t;

endpackage
`default_nettype wire

// File: src/utilization_admission_control.sv
// Utilization admission control for one CPU: keeps a base period and the time reserved in it.
// Each input beat carries a task (runtime, period, deadline in ns) and an op in tuser: check
// whether the task fits under limit_percent, or add its reservation. When the base is not a
// multiple of the deadline the block realigns it to a common multiple of base and period,
// searching upward in 1000 ns steps, and scales the reserved time. One request is worked at a
// time by a sequencer driving one iterative divider and one iterative multiplier. A zero period
// or deadline is answered with the zero status once the beat is taken; a request without
// realignment takes 5 unit operations for an add or 7 for a check; with realignment it takes
// 11 or 13 operations plus a search that tries one candidate per cycle, at most
// MAX_SEARCH_STEPS candidates. Error cases end early. A result sits in an output register,
// so the next request is taken while it waits.
`default_nettype none
module utilization_admission_control #(
  parameter longint unsigned MAX_SEARCH_STEPS = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: task_runtime[31:0], task_period[63:32], task_deadline[95:64]
  input  wire logic [95:0]  in_tdata,
  // in_tuser: op
  input  wire logic         in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata: status[2:0], base_out[66:3], used_out[130:67], zero pad[135:131]
  output logic [135:0]      out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata
);
  import uac_pkg::*;

  localparam int KW = $clog2(MAX_SEARCH_STEPS + 64'd1);

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_DMOD  = 18'b000000000000000010,
    S_BRES  = 18'b000000000000000100,
    S_PRES  = 18'b000000000000001000,
    S_CRB   = 18'b000000000000010000,
    S_CRP   = 18'b000000000000100000,
    S_SRCH  = 18'b000000000001000000,
    S_FACT  = 18'b000000000010000000,
    S_SCALE = 18'b000000000100000000,
    S_QR    = 18'b000000001000000000,
    S_SHARE = 18'b000000010000000000,
    S_PMUL  = 18'b000000100000000000,
    S_PDIV  = 18'b000001000000000000,
    S_SUM   = 18'b000010000000000000,
    S_LMUL  = 18'b000100000000000000,
    S_RMUL  = 18'b001000000000000000,
    S_DONE  = 18'b010000000000000000,
    S_PAD   = 18'b100000000000000000
  } state_t;

  state_t            state_r;
  logic              go_r;
  logic [LIM_W-1:0]  limit_r;
  logic [WORD_W-1:0] base_period_r;
  logic [WORD_W-1:0] used_r;

  logic              op_r;
  logic [HALF_W-1:0] rt_r;
  logic [HALF_W-1:0] per_r;
  logic [HALF_W-1:0] dl_r;
  logic [WORD_W-1:0] wb_r;
  logic [WORD_W-1:0] wu_r;
  logic [WORD_W-1:0] cand_r;
  logic [WORD_W-1:0] rb_r;
  logic [HALF_W-1:0] rp_r;
  logic [KW-1:0]     k_r;
  logic [WORD_W-1:0] tmp_r;
  logic [HALF_W-1:0] rr_r;
  logic [WORD_W-1:0] share_r;
  logic [CMP_W-1:0]  lhs_r;
  logic              realign_r;
  logic [ST_W-1:0]   st_r;

  logic              out_tvalid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [WORD_W-1:0] out_base_r;
  logic [WORD_W-1:0] out_used_r;

  div_req_t div_req;
  div_res_t div_res;
  mul_req_t mul_req;
  mul_res_t mul_res;
  logic     use_div;
  logic     use_mul;

  logic              in_fire;
  logic              out_free;
  logic [WORD_W:0]   rb_add;
  logic [WORD_W-1:0] rb_step;
  logic [HALF_W:0]   rp_add;
  logic [HALF_W-1:0] rp_step;
  logic              found;
  logic              cand_top;
  logic [WORD_W:0]   part_sum;
  logic [WORD_W:0]   tot_sum;

  uac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  uac_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .res   (mul_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // operand select for the shared units
  always_comb begin
    use_div         = 1'b0;
    use_mul         = 1'b0;
    div_req.dividend = wb_r;
    div_req.divisor  = {32'b0, per_r};
    mul_req.a        = wu_r;
    mul_req.b        = tmp_r;
    case (state_r)
      S_DMOD: begin
        use_div         = 1'b1;
        div_req.divisor = {32'b0, dl_r};
      end
      S_BRES: begin
        use_div         = 1'b1;
        div_req.divisor = STEP_NS;
      end
      S_PRES: begin
        use_div          = 1'b1;
        div_req.dividend = {32'b0, per_r};
        div_req.divisor  = STEP_NS;
      end
      S_CRB, S_FACT: begin
        use_div          = 1'b1;
        div_req.dividend = cand_r;
        div_req.divisor  = wb_r;
      end
      S_CRP: begin
        use_div          = 1'b1;
        div_req.dividend = cand_r;
      end
      S_QR: begin
        use_div = 1'b1;
      end
      S_PDIV: begin
        use_div          = 1'b1;
        div_req.dividend = tmp_r;
      end
      S_SCALE: begin
        use_mul = 1'b1;
      end
      S_SHARE: begin
        use_mul   = 1'b1;
        mul_req.a = {32'b0, rt_r};
      end
      S_PMUL: begin
        use_mul   = 1'b1;
        mul_req.a = {32'b0, rt_r};
        mul_req.b = {32'b0, rr_r};
      end
      S_LMUL: begin
        use_mul   = 1'b1;
        mul_req.a = share_r;
        mul_req.b = PCT_SCALE;
      end
      S_RMUL: begin
        use_mul   = 1'b1;
        mul_req.a = wb_r;
        mul_req.b = {{(WORD_W-LIM_W){1'b0}}, limit_r};
      end
      default: begin
        use_div = 1'b0;
      end
    endcase
    div_req.start = use_div && !go_r;
    mul_req.start = use_mul && !go_r;
  end

  // one candidate per cycle: advance both running remainders by one step
  always_comb begin
    rb_add   = {1'b0, rb_r} + {1'b0, STEP_NS};
    rp_add   = {1'b0, rp_r} + (HALF_W+1)'(STEP_NS);
    if (wb_r == 64'd1) begin
      rb_step = '0;
    end else if (rb_add >= {1'b0, wb_r}) begin
      rb_step = WORD_W'(rb_add - {1'b0, wb_r});
    end else begin
      rb_step = rb_add[WORD_W-1:0];
    end
    if (rp_add >= {1'b0, per_r}) begin
      rp_step = HALF_W'(rp_add - {1'b0, per_r});
    end else begin
      rp_step = rp_add[HALF_W-1:0];
    end
    found    = (rb_r == '0) && (rp_r == '0);
    cand_top = cand_r > ({WORD_W{1'b1}} - STEP_NS);
    part_sum = {1'b0, share_r} + {1'b0, div_res.quot};
    tot_sum  = {1'b0, wu_r} + {1'b0, share_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      go_r          <= 1'b0;
      limit_r       <= LIMIT_RST;
      base_period_r <= 64'd1;
      used_r        <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (div_req.start || mul_req.start) begin
        go_r <= 1'b1;
      end else if (div_res.done || mul_res.done) begin
        go_r <= 1'b0;
      end

      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r      <= in_tuser;
            rt_r      <= in_tdata[31:0];
            per_r     <= in_tdata[63:32];
            dl_r      <= in_tdata[95:64];
            wb_r      <= base_period_r;
            wu_r      <= used_r;
            realign_r <= 1'b0;
            if (in_tdata[63:32] == '0 || in_tdata[95:64] == '0) begin
              st_r    <= ST_ZERO;
              state_r <= S_DONE;
            end else begin
              state_r <= S_DMOD;
            end
          end
        end
        S_DMOD: begin
          if (div_res.done) begin
            state_r <= (div_res.rem == '0) ? S_QR : S_BRES;
          end
        end
        S_BRES: begin
          if (div_res.done) begin
            if (wb_r != 64'd1 && div_res.rem != '0) begin
              st_r    <= ST_BADRES;
              state_r <= S_DONE;
            end else begin
              state_r <= S_PRES;
            end
          end
        end
        S_PRES: begin
          if (div_res.done) begin
            if (div_res.rem != '0) begin
              st_r    <= ST_BADRES;
              state_r <= S_DONE;
            end else begin
              cand_r  <= (wb_r > {32'b0, per_r}) ? wb_r : {32'b0, per_r};
              state_r <= S_CRB;
            end
          end
        end
        S_CRB: begin
          if (div_res.done) begin
            rb_r    <= div_res.rem;
            state_r <= S_CRP;
          end
        end
        S_CRP: begin
          if (div_res.done) begin
            rp_r    <= div_res.rem[HALF_W-1:0];
            k_r     <= '0;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (k_r == KW'(MAX_SEARCH_STEPS)) begin
            st_r    <= ST_LIMIT;
            state_r <= S_DONE;
          end else if (found) begin
            state_r <= S_FACT;
          end else if (cand_top) begin
            st_r    <= ST_LIMIT;
            state_r <= S_DONE;
          end else begin
            cand_r <= cand_r + STEP_NS;
            rb_r   <= rb_step;
            rp_r   <= rp_step;
            k_r    <= k_r + 1'b1;
          end
        end
        S_FACT: begin
          if (div_res.done) begin
            tmp_r   <= div_res.quot;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mul_res.done) begin
            if (mul_res.prod[PROD_W-1:WORD_W] != '0) begin
              st_r    <= ST_LIMIT;
              state_r <= S_DONE;
            end else begin
              wu_r      <= mul_res.prod[WORD_W-1:0];
              wb_r      <= cand_r;
              realign_r <= 1'b1;
              state_r   <= S_QR;
            end
          end
        end
        S_QR: begin
          if (div_res.done) begin
            tmp_r   <= div_res.quot;
            rr_r    <= div_res.rem[HALF_W-1:0];
            state_r <= S_SHARE;
          end
        end
        S_SHARE: begin
          if (mul_res.done) begin
            if (mul_res.prod[PROD_W-1:WORD_W] != '0) begin
              st_r    <= ST_LIMIT;
              state_r <= S_DONE;
            end else begin
              share_r <= mul_res.prod[WORD_W-1:0];
              state_r <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          if (mul_res.done) begin
            tmp_r   <= mul_res.prod[WORD_W-1:0];
            state_r <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_res.done) begin
            if (part_sum[WORD_W]) begin
              st_r    <= ST_LIMIT;
              state_r <= S_DONE;
            end else begin
              share_r <= part_sum[WORD_W-1:0];
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (tot_sum[WORD_W]) begin
            st_r    <= ST_LIMIT;
            state_r <= S_DONE;
          end else if (op_r == OP_ADD) begin
            base_period_r <= wb_r;
            used_r        <= tot_sum[WORD_W-1:0];
            st_r          <= realign_r ? ST_REALIGN : ST_FIT;
            state_r       <= S_DONE;
          end else begin
            share_r <= tot_sum[WORD_W-1:0];
            state_r <= S_LMUL;
          end
        end
        S_LMUL: begin
          if (mul_res.done) begin
            lhs_r   <= mul_res.prod[CMP_W-1:0];
            state_r <= S_RMUL;
          end
        end
        S_RMUL: begin
          if (mul_res.done) begin
            if (lhs_r > mul_res.prod[CMP_W-1:0]) begin
              st_r <= ST_NOSPACE;
            end else begin
              st_r <= realign_r ? ST_REALIGN : ST_FIT;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_status_r <= st_r;
            out_base_r   <= base_period_r;
            out_used_r   <= used_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'b0, out_used_r, out_base_r, out_status_r};

endmodule
`default_nettype wire

// File: src/uac_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend and divisor.
`default_nettype none
module uac_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  var  uac_pkg::div_req_t req,
  output var  uac_pkg::div_res_t res
);
  import uac_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W+1:0] trial;

  // shift in the next dividend bit and try the subtract
  assign trial = {1'b0, rem_r, quo_r[WORD_W-1]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WORD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      if (trial[WORD_W+1]) begin
        rem_r <= {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
      end else begin
        rem_r <= trial[WORD_W-1:0];
      end
      quo_r <= {quo_r[WORD_W-2:0], ~trial[WORD_W+1]};
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule
`default_nettype wire

// File: src/uac_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, full 128-bit product.
`default_nettype none
module uac_mul (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  var  uac_pkg::mul_req_t req,
  output var  uac_pkg::mul_res_t res
);
  import uac_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] hi_r;
  logic [WORD_W-1:0] lo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W:0]   sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WORD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // multiplier bits leave lo_r from the bottom as product bits enter the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      hi_r <= '0;
      lo_r <= req.b;
    end else if (busy_r) begin
      hi_r <= sum[WORD_W:1];
      lo_r <= {sum[0], lo_r[WORD_W-1:1]};
    end
  end

  assign res.done = done_r;
  assign res.prod = {hi_r, lo_r};

endmodule
`default_nettype wire
